// ===== rtl/dyck_height_bit_flip_maps_top_assert.svh =====
// ----------------------------------------------------------------------------
// Dyck height bit flip maps: assertion macros
// Concurrent assertion wrappers clocked on clk; DHBF_ASSERT is quiet while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DYCK_HEIGHT_BIT_FLIP_MAPS_TOP_ASSERT_SVH
`define DYCK_HEIGHT_BIT_FLIP_MAPS_TOP_ASSERT_SVH

// check a property on every clock edge outside reset
`define DHBF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check a property on every clock edge, reset included
`define DHBF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/dhbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhbf_pkg
// Shared widths, mode codes, item record and mask helper for the bit flip maps.
// ----------------------------------------------------------------------------
package dhbf_pkg;

	localparam int WORD_W            = 64;
	localparam int LEN_W             = 7;
	localparam int MAX_WORD_BITS_DEF = 64;

	typedef enum logic [1:0] {
		MODE_G    = 2'd0,
		MODE_H    = 2'd1,
		MODE_GH   = 2'd2,
		MODE_NONE = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic              ok;
		logic [WORD_W-1:0] orig;
		logic [WORD_W-1:0] word;
	} item_t;

	// bits strictly below position pos
	function automatic logic [WORD_W-1:0] low_mask(input int pos);
		low_mask = (WORD_W'(1) << pos) - WORD_W'(1);
	endfunction

endpackage

// ===== rtl/dhbf_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhbf_map
// Three stage flip map: set map (CLEAR = 0) or clear map (CLEAR = 1).
// Stage 1 marks candidates by height, stage 2 counts and ranks them,
// stage 3 picks the target bit and flips it.
// ----------------------------------------------------------------------------
module dhbf_map #(
	parameter bit CLEAR = 1'b0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_vld,
	input  dhbf_pkg::item_t                     in_item,
	input  logic [dhbf_pkg::WORD_W-1:0]         len_mask,
	output logic                                out_vld,
	output dhbf_pkg::item_t                     out_item
);

	localparam int W  = dhbf_pkg::WORD_W;
	localparam int LW = dhbf_pkg::LEN_W;

	logic [LW-1:0]   ones_below [W];
	logic [W-1:0]    at_h0;
	logic [W-1:0]    at_h1;
	logic [W-1:0]    flag_c;
	logic [W-1:0]    cand_c;

	logic            vld_s1;
	dhbf_pkg::item_t item_s1;
	logic [W-1:0]    flag_s1;
	logic [W-1:0]    cand_s1;

	logic            vld_s2;
	dhbf_pkg::item_t item_s2;
	logic [W-1:0]    cand_s2;
	logic [LW-1:0]   cnt_s2;
	logic [LW-1:0]   rank_s2 [W];

	logic [W-1:0]    hit_c;
	logic            en_c;
	logic            hit_any_c;
	dhbf_pkg::item_t item_c;

	logic            vld_s3;
	dhbf_pkg::item_t item_s3;

	// mark positions by height
	always_comb begin
		for (int i = 0; i < W; i++) begin
			ones_below[i] = LW'($countones(in_item.word & dhbf_pkg::low_mask(i)));
			at_h0[i] = ({ones_below[i], 1'b0} == (LW+1)'(i));
			at_h1[i] = ({ones_below[i], 1'b0} == (LW+1)'(i + 1));
			if (CLEAR) begin
				flag_c[i] = len_mask[i] & in_item.word[i] & at_h1[i];
				cand_c[i] = len_mask[i] & in_item.word[i] & (at_h0[i] | at_h1[i]);
			end else begin
				flag_c[i] = len_mask[i] & ~in_item.word[i] & at_h0[i];
				cand_c[i] = len_mask[i] & ~in_item.word[i] & (at_h0[i] | at_h1[i]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
		flag_s1 <= flag_c;
		cand_s1 <= cand_c;
		item_s2 <= item_s1;
		cand_s2 <= cand_s1;
		cnt_s2  <= LW'($countones(flag_s1));
		for (int i = 0; i < W; i++) begin
			rank_s2[i] <= LW'($countones(cand_s1 & dhbf_pkg::low_mask(i)));
		end
		item_s3 <= item_c;
	end

	// pick the target candidate and flip it
	always_comb begin
		if (CLEAR) begin
			en_c = (item_s2.mode == dhbf_pkg::MODE_H) || (item_s2.mode == dhbf_pkg::MODE_GH);
		end else begin
			en_c = (item_s2.mode == dhbf_pkg::MODE_G) || (item_s2.mode == dhbf_pkg::MODE_GH);
		end
		for (int i = 0; i < W; i++) begin
			if (CLEAR) begin
				hit_c[i] = cand_s2[i] && (cnt_s2 != '0) && (rank_s2[i] == cnt_s2 - LW'(1));
			end else begin
				hit_c[i] = cand_s2[i] && (rank_s2[i] == cnt_s2);
			end
		end
		hit_any_c = |hit_c;
		item_c    = item_s2;
		if (en_c) begin
			item_c.ok = item_s2.ok & hit_any_c;
			if (hit_any_c) begin
				item_c.word = CLEAR ? (item_s2.word & ~hit_c) : (item_s2.word | hit_c);
			end
		end
	end

	assign out_vld  = vld_s3;
	assign out_item = item_s3;

endmodule

// ===== rtl/dyck_height_bit_flip_maps_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dyck_height_bit_flip_maps_top
// Middle levels Gray code step: set map, clear map or both on one word.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// command   in         start, busy           mode, word_in
// result    out        done (one cycle)      word_out, found
// config    in         cfg_valid, cfg_ready  cfg_data (word_length)
//
// One item per cycle; busy stays low and cfg_ready stays high.
// From start to done an item passes the input register, three stages of
// the set map, three stages of the clear map and the result register.
// Reset clears the pipeline valids and sets word_length to 64.
// The receiver takes done as given; nothing stalls.
// ----------------------------------------------------------------------------
module dyck_height_bit_flip_maps_top #(
	parameter int MAX_WORD_BITS = dhbf_pkg::MAX_WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    mode,
	input  logic [dhbf_pkg::WORD_W-1:0]   word_in,
	output logic                          done,
	output logic [dhbf_pkg::WORD_W-1:0]   word_out,
	output logic                          found,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dhbf_pkg::LEN_W-1:0]    cfg_data
);

	localparam int W  = dhbf_pkg::WORD_W;
	localparam int LW = dhbf_pkg::LEN_W;

	logic [LW-1:0]   word_length_q;
	logic [LW-1:0]   eff_len;
	logic [W-1:0]    len_mask;

	logic            vld_s0;
	dhbf_pkg::item_t item_s0;
	logic            vld_g;
	dhbf_pkg::item_t item_g;
	logic            vld_h;
	dhbf_pkg::item_t item_h;
	logic            found_c;

	logic            done_q;
	logic            found_q;
	logic [W-1:0]    word_out_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_length_q <= LW'(64);
		end else if (cfg_valid && cfg_ready) begin
			word_length_q <= cfg_data;
		end
	end

	// clamp length and expand to a position mask
	always_comb begin
		eff_len = (word_length_q > LW'(MAX_WORD_BITS)) ? LW'(MAX_WORD_BITS) : word_length_q;
		for (int i = 0; i < W; i++) begin
			len_mask[i] = (LW'(i) < eff_len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s0 <= start && !busy;
			done_q <= vld_h;
		end
	end

	always_ff @(posedge clk) begin
		item_s0.mode <= mode;
		item_s0.ok   <= 1'b1;
		item_s0.orig <= word_in;
		item_s0.word <= word_in;
		found_q      <= found_c;
		word_out_q   <= found_c ? item_h.word : item_h.orig;
	end

	dhbf_map #(
		.CLEAR(1'b0)
	) u_map_g (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s0),
		.in_item  (item_s0),
		.len_mask (len_mask),
		.out_vld  (vld_g),
		.out_item (item_g)
	);

	dhbf_map #(
		.CLEAR(1'b1)
	) u_map_h (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_g),
		.in_item  (item_g),
		.len_mask (len_mask),
		.out_vld  (vld_h),
		.out_item (item_h)
	);

	// drop the unused mode
	assign found_c = item_h.ok && (item_h.mode != dhbf_pkg::MODE_NONE);

	assign done     = done_q;
	assign found    = found_q;
	assign word_out = word_out_q;

`include "dyck_height_bit_flip_maps_top_assert.svh"

	`DHBF_ASSERT(a_latency, start |-> ##8 done, "done missing 8 cycles after start")
	`DHBF_ASSERT(a_miss_passes, done && !found |-> word_out == $past(word_in, 8), "word changed")
	`DHBF_ASSERT(a_none_fails, done && found |-> $past(mode, 8) != dhbf_pkg::MODE_NONE, "bad found")
	`DHBF_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !done, "done during reset")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives words through the bit flip maps across several word lengths and
// idle patterns, predicts each result with its own set/clear map model and
// compares word and flag of every done strobe in order.
// ----------------------------------------------------------------------------

class flip_map_scoreboard;

	typedef struct {
		logic [dhbf_pkg::WORD_W-1:0] word;
		logic                        found;
	} flip_result_t;

	flip_result_t                expected_flips[$];
	logic [dhbf_pkg::LEN_W-1:0]  len_reg;
	int                          fail_count;

	function new();
		len_reg    = dhbf_pkg::LEN_W'(64);
		fail_count = 0;
	endfunction

	function void set_length(logic [dhbf_pkg::LEN_W-1:0] v);
		len_reg = v;
	endfunction

	function int pending();
		return expected_flips.size();
	endfunction

	function int failures();
		return fail_count;
	endfunction

	function void note_failure(string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("mismatch %0d: %s", fail_count, msg);
		end
	endfunction

	// set the (d0+1)-th zero at height 0 or 1
	function bit set_zero(logic [dhbf_pkg::WORD_W-1:0] x, int n,
			output logic [dhbf_pkg::WORD_W-1:0] r);
		int h;
		int d0;
		int seen;
		r  = x;
		h  = 0;
		d0 = 0;
		for (int i = 0; i < n; i++) begin
			if (!x[i] && h == 0) d0++;
			h += x[i] ? 1 : -1;
		end
		h    = 0;
		seen = 0;
		for (int i = 0; i < n; i++) begin
			if (!x[i] && (h == 0 || h == 1)) begin
				seen++;
				if (seen == d0 + 1) begin
					r[i] = 1'b1;
					return 1'b1;
				end
			end
			h += x[i] ? 1 : -1;
		end
		return 1'b0;
	endfunction

	// clear the u1-th one at height 0 or 1
	function bit clear_one(logic [dhbf_pkg::WORD_W-1:0] y, int n,
			output logic [dhbf_pkg::WORD_W-1:0] r);
		int h;
		int u1;
		int seen;
		r  = y;
		h  = 0;
		u1 = 0;
		for (int i = 0; i < n; i++) begin
			if (y[i] && h == 1) u1++;
			h += y[i] ? 1 : -1;
		end
		h    = 0;
		seen = 0;
		for (int i = 0; i < n; i++) begin
			if (y[i] && (h == 0 || h == 1)) begin
				seen++;
				if (seen == u1) begin
					r[i] = 1'b0;
					return 1'b1;
				end
			end
			h += y[i] ? 1 : -1;
		end
		return 1'b0;
	endfunction

	function void note_word(dhbf_pkg::mode_t m, logic [dhbf_pkg::WORD_W-1:0] w);
		flip_result_t                e;
		logic [dhbf_pkg::WORD_W-1:0] a;
		logic [dhbf_pkg::WORD_W-1:0] b;
		bit                          ok;
		int                          n;
		n  = (int'(len_reg) > dhbf_pkg::MAX_WORD_BITS_DEF) ?
			dhbf_pkg::MAX_WORD_BITS_DEF : int'(len_reg);
		a  = w;
		b  = w;
		ok = 1'b0;
		unique case (m)
			dhbf_pkg::MODE_G: begin
				ok = set_zero(w, n, a);
				b  = a;
			end
			dhbf_pkg::MODE_H: ok = clear_one(w, n, b);
			dhbf_pkg::MODE_GH: begin
				ok = set_zero(w, n, a);
				if (ok) ok = clear_one(a, n, b);
			end
			default: ok = 1'b0;
		endcase
		e.word  = ok ? b : w;
		e.found = ok;
		expected_flips.insert(expected_flips.size(), e);
	endfunction

	function void check_result(logic [dhbf_pkg::WORD_W-1:0] w, logic f);
		flip_result_t e;
		if (expected_flips.size() == 0) begin
			note_failure($sformatf("unexpected result word=%h found=%b", w, f));
			return;
		end
		e = expected_flips.pop_front();
		if (w !== e.word) begin
			note_failure($sformatf("word_out exp=%h act=%h", e.word, w));
		end
		if (f !== e.found) begin
			note_failure($sformatf("found exp=%b act=%b (word exp=%h)", e.found, f, e.word));
		end
	endfunction

endclass

module tb_top;

	localparam int LATENCY = 8;

	typedef struct {
		dhbf_pkg::mode_t             m;
		logic [dhbf_pkg::WORD_W-1:0] w;
	} directed_item_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        start     = 1'b0;
	logic                        busy;
	dhbf_pkg::mode_t             mode      = dhbf_pkg::MODE_G;
	logic [dhbf_pkg::WORD_W-1:0] word_in   = '0;
	logic                        done;
	logic [dhbf_pkg::WORD_W-1:0] word_out;
	logic                        found;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [dhbf_pkg::LEN_W-1:0]  cfg_data  = '0;

	flip_map_scoreboard sb;
	int                 cur_len;

	dyck_height_bit_flip_maps_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.mode      (mode),
		.word_in   (word_in),
		.done      (done),
		.word_out  (word_out),
		.found     (found),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) sb.note_word(mode, word_in);
			if (done) sb.check_result(word_out, found);
			if (cfg_valid && cfg_ready) sb.set_length(cfg_data);
		end
	end

	task automatic send_item(dhbf_pkg::mode_t m, logic [dhbf_pkg::WORD_W-1:0] w,
			int idle_pct);
		start   <= 1'b1;
		mode    <= m;
		word_in <= w;
		do @(posedge clk); while (busy);
		while ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic write_length(int v);
		cfg_valid <= 1'b1;
		cfg_data  <= dhbf_pkg::LEN_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_len = (v > dhbf_pkg::MAX_WORD_BITS_DEF) ? dhbf_pkg::MAX_WORD_BITS_DEF : v;
	endtask

	function automatic dhbf_pkg::mode_t pick_mode();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return dhbf_pkg::MODE_G;
		if (r < 60) return dhbf_pkg::MODE_H;
		if (r < 92) return dhbf_pkg::MODE_GH;
		return dhbf_pkg::MODE_NONE;
	endfunction

	function automatic logic [dhbf_pkg::WORD_W-1:0] make_word(int n);
		logic [dhbf_pkg::WORD_W-1:0] w;
		int                          kind;
		int                          h;
		int                          ones;
		int                          target;
		int                          p;
		w    = {$urandom, $urandom};
		kind = $urandom_range(0, 99);
		if (n == 0) return w;
		if (kind < 45) begin
			// middle level word: half the active bits set
			for (int i = 0; i < n; i++) w[i] = 1'b0;
			target = $urandom_range(n / 2, (n + 1) / 2);
			ones   = 0;
			while (ones < target) begin
				p = $urandom_range(0, n - 1);
				if (!w[p]) begin
					w[p] = 1'b1;
					ones++;
				end
			end
		end else if (kind < 75) begin
			// keep the walk close to height zero
			h = 0;
			for (int i = 0; i < n; i++) begin
				if (h <= 0) w[i] = ($urandom_range(0, 99) < 65);
				else if (h >= 2) w[i] = ($urandom_range(0, 99) < 30);
				else w[i] = 1'($urandom_range(0, 1));
				h += w[i] ? 1 : -1;
			end
		end else if (kind < 85) begin
			w = w & {$urandom, $urandom} & {$urandom, $urandom};
		end else if (kind < 95) begin
			w = w | {$urandom, $urandom} | {$urandom, $urandom};
		end
		return w;
	endfunction

	initial begin
		directed_item_t directed[$];
		int             lens[$];
		int             idle_pct;

		sb      = new();
		cur_len = 64;
		directed = '{
			'{dhbf_pkg::MODE_G,    64'h0},
			'{dhbf_pkg::MODE_H,    64'h0},
			'{dhbf_pkg::MODE_GH,   64'h0},
			'{dhbf_pkg::MODE_NONE, 64'h0},
			'{dhbf_pkg::MODE_G,    '1},
			'{dhbf_pkg::MODE_H,    '1},
			'{dhbf_pkg::MODE_GH,   '1},
			'{dhbf_pkg::MODE_NONE, '1},
			'{dhbf_pkg::MODE_G,    64'h5555_5555_5555_5555},
			'{dhbf_pkg::MODE_H,    64'h5555_5555_5555_5555},
			'{dhbf_pkg::MODE_GH,   64'hAAAA_AAAA_AAAA_AAAA},
			'{dhbf_pkg::MODE_H,    64'hAAAA_AAAA_AAAA_AAAA},
			'{dhbf_pkg::MODE_G,    64'hAAAA_AAAA_AAAA_AAAA},
			'{dhbf_pkg::MODE_H,    64'h1},
			'{dhbf_pkg::MODE_H,    64'h3},
			'{dhbf_pkg::MODE_G,    64'h1},
			'{dhbf_pkg::MODE_GH,   64'h2},
			'{dhbf_pkg::MODE_G,    64'h8000_0000_0000_0000},
			'{dhbf_pkg::MODE_H,    64'h8000_0000_0000_0000},
			'{dhbf_pkg::MODE_GH,   64'h0000_0000_FFFF_FFFF},
			'{dhbf_pkg::MODE_GH,   64'hFFFF_FFFF_0000_0000},
			'{dhbf_pkg::MODE_GH,   64'h0000_0000_5555_5555}
		};
		lens = '{13, 1, 64, 0, 127, 2, 63, 65, 21, 64, 7, 100};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset length of 64 first
		foreach (directed[i]) send_item(directed[i].m, directed[i].w, 25);
		drain();

		foreach (lens[p]) begin
			write_length(lens[p]);
			idle_pct = (p < 4) ? 25 : (p < 8) ? 56 : 0;
			repeat (140) send_item(pick_mode(), make_word(cur_len), idle_pct);
			drain();
		end

		repeat (LATENCY + 4) @(posedge clk);
		if (sb.failures() == 0 && sb.pending() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== dyck_height_bit_flip_maps_top.f =====
+incdir+rtl
rtl/dhbf_pkg.sv
rtl/dhbf_map.sv
rtl/dyck_height_bit_flip_maps_top.sv
dv/tb_top.sv
